/* sv/assert_macros.svh */
//------------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define OVL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every rising clock edge outside reset.
`define OVL_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

`endif

/* sv/ovl_pkg.sv */
//------------------------------------------------------------------------------
// ovl_pkg
// Widths, command and status codes, and cell control type of the value list.
//------------------------------------------------------------------------------
package ovl_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int DATA_W   = 32;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [KIND_W-1:0] KIND_FRONT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BACK   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

   // Broadcast to every cell of the row.
   typedef struct packed {
      logic shift_right;   // all cells take the left neighbor (front insert)
      logic append;        // the cell at index count takes the value
      logic capture;       // cells register their compare result
      logic shift_left;    // cells at and after the first match take the right neighbor
   } cell_ctl_type;

endpackage

/* sv/ovl_if.sv */
//------------------------------------------------------------------------------
// ovl_if
// Valid/ready channels for commands and results of the value list.
//------------------------------------------------------------------------------
interface ovl_req_if;
   logic                                valid;
   logic                                ready;
   logic [ovl_pkg::KIND_W-1:0]          kind;
   logic signed [ovl_pkg::DATA_W-1:0]   value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface ovl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ovl_pkg::STATUS_W-1:0]        status;
   logic [ovl_pkg::COUNT_W-1:0]         entry_count;
   logic signed [ovl_pkg::DATA_W-1:0]   last_value;
   logic                                last_valid;

   modport source (output valid, output status, output entry_count, output last_value,
                   output last_valid, input ready);
   modport sink   (input valid, input status, input entry_count, input last_value,
                   input last_valid, output ready);
endinterface

/* sv/ovl_cell.sv */
//------------------------------------------------------------------------------
// ovl_cell
// One list slot: holds an entry, compares it and trades it with its neighbors.
//------------------------------------------------------------------------------
module ovl_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  ovl_pkg::cell_ctl_type               ctl,
   input  logic [ovl_pkg::IDX_W-1:0]           cell_idx,
   input  logic [ovl_pkg::CNT_W-1:0]           count,
   input  logic signed [ovl_pkg::DATA_W-1:0]   value,
   input  logic signed [ovl_pkg::DATA_W-1:0]   left_data,
   input  logic signed [ovl_pkg::DATA_W-1:0]   right_data,
   input  logic                                seen_in,
   output logic                                seen_out,
   output logic signed [ovl_pkg::DATA_W-1:0]   data
);
   import ovl_pkg::*;

   logic signed [DATA_W-1:0] data_ff;
   logic                     match_ff;
   logic                     occupied;
   logic [CNT_W-1:0]         idx_ext;

   assign idx_ext  = CNT_W'(cell_idx);
   assign occupied = idx_ext < count;
   // Match seen here or anywhere toward the front.
   assign seen_out = seen_in | match_ff;
   assign data     = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (ctl.capture) begin
         match_ff <= occupied && (data_ff == value);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift_right) begin
         data_ff <= left_data;
      end else if (ctl.append && (idx_ext == count)) begin
         data_ff <= value;
      end else if (ctl.shift_left && seen_out) begin
         data_ff <= right_data;
      end
   end

endmodule

/* sv/ordered_value_list.sv */
//------------------------------------------------------------------------------
// ordered_value_list
// Bounded ordered list of signed 32-bit values: front insert, back append,
// remove first equal entry.
//------------------------------------------------------------------------------
// One command is handled at a time. Insert, append and unused kinds go
// through accept, update the cell row, read the back entry into the result
// register and present, and the result is offered in the present step.
// Remove splits the update into a compare step and a shift step, since
// every cell first registers its compare and the row then closes the gap
// in the following cycle. The cell row does one whole-row update per cycle,
// and the back-entry read is registered; a stall on the result side holds
// the result in the present step. The next command is taken once the
// result has been accepted. Reset clears the entry count at once; slot
// contents need no clearing, as only slots below the count are ever read.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_value_list (
   input  logic       clock,
   input  logic       reset,
   ovl_req_if.sink    req_ch,
   ovl_rsp_if.source  rsp_ch
);
   import ovl_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SHIFT,
      S_LOAD,
      S_RESP
   } state_type;

   state_type                state_ff;
   logic [KIND_W-1:0]        kind_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [STATUS_W-1:0]      status_ff;
   logic signed [DATA_W-1:0] last_ff;
   logic                     last_valid_ff;

   cell_ctl_type             ctl;
   logic                     full;
   logic                     found;
   logic [IDX_W-1:0]         last_idx;
   logic signed [DATA_W-1:0] cell_data [CAPACITY];
   logic                     seen [CAPACITY+1];

   assign full     = count_ff == CNT_W'(CAPACITY);
   assign found    = seen[CAPACITY];
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));

   always_comb begin
      ctl.shift_right = (state_ff == S_EXEC) && (kind_ff == KIND_FRONT) && !full;
      ctl.append      = (state_ff == S_EXEC) && (kind_ff == KIND_BACK) && !full;
      ctl.capture     = (state_ff == S_EXEC) && (kind_ff == KIND_REMOVE);
      ctl.shift_left  = state_ff == S_SHIFT;
   end

   assign seen[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_d;
      logic signed [DATA_W-1:0] right_d;

      // The front cell's left neighbor is the incoming value.
      if (i == 0) begin : g_front
         assign left_d = value_ff;
      end else begin : g_inner
         assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_back
         assign right_d = cell_data[i];
      end else begin : g_mid
         assign right_d = cell_data[i+1];
      end

      ovl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .cell_idx   (IDX_W'(i)),
         .count      (count_ff),
         .value      (value_ff),
         .left_data  (left_d),
         .right_data (right_d),
         .seen_in    (seen[i]),
         .seen_out   (seen[i+1]),
         .data       (cell_data[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         status_ff     <= ST_DONE;
         last_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  kind_ff  <= req_ch.kind;
                  value_ff <= req_ch.value;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               status_ff <= ST_DONE;
               state_ff  <= S_LOAD;
               if (kind_ff == KIND_FRONT || kind_ff == KIND_BACK) begin
                  if (full) begin
                     status_ff <= ST_FULL;
                  end else begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
               end else if (kind_ff == KIND_REMOVE) begin
                  state_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               if (found) begin
                  count_ff  <= count_ff - CNT_W'(1);
                  status_ff <= ST_DONE;
               end else begin
                  status_ff <= ST_ABSENT;
               end
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               last_valid_ff <= count_ff != '0;
               last_ff       <= (count_ff != '0) ? cell_data[last_idx] : '0;
               state_ff      <= S_RESP;
            end
            S_RESP: begin
               if (rsp_ch.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready       = state_ff == S_IDLE;
   assign rsp_ch.valid       = state_ff == S_RESP;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.entry_count = COUNT_W'(count_ff);
   assign rsp_ch.last_value  = last_ff;
   assign rsp_ch.last_valid  = last_valid_ff;

   `OVL_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "count over capacity")
   `OVL_ASSERT_IMPL(a_last_valid, clock, reset, rsp_ch.valid, rsp_ch.last_valid == (count_ff != '0), "last_valid disagrees with count")
   `OVL_ASSERT_IMPL(a_accept_exec, clock, reset, req_ch.valid && req_ch.ready, ##1 state_ff == S_EXEC, "accepted item not executed")
   `OVL_ASSERT_IMPL(a_shift_remove, clock, reset, state_ff == S_SHIFT, $past(state_ff) == S_EXEC && kind_ff == KIND_REMOVE, "shift without remove")
   `OVL_ASSERT_IMPL(a_full_status, clock, reset, rsp_ch.valid && rsp_ch.status == ST_FULL, count_ff == CNT_W'(CAPACITY), "full status with room left")

endmodule
